// File: hw/rtl/idpr_pkg.sv
// shared types and constants of the int8 dot product requantize block
package idpr_pkg;

	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 9;

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] REG_LHS_ZP     = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_OUT_OFFSET = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_ACT_MIN    = 2'd2;
	localparam logic [CfgIndexWidth-1:0] REG_ACT_MAX    = 2'd3;

	localparam logic signed [8:0] LhsZpReset     = 9'sd0;
	localparam logic signed [7:0] OutOffsetReset = 8'sd0;
	localparam logic signed [7:0] ActMinReset    = -8'sd128;
	localparam logic signed [7:0] ActMaxReset    = 8'sd127;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MUL,
		ST_HIGH,
		ST_ROUND,
		ST_FINISH
	} idpr_state_t;

	typedef struct packed {
		logic mac;
		logic shift;
		logic mul;
		logic high;
		logic rnd;
		logic finish;
	} idpr_cmd_t;

	typedef struct packed {
		logic signed [8:0] lhs_zp;
		logic signed [7:0] out_offset;
		logic signed [7:0] act_min;
		logic signed [7:0] act_max;
	} idpr_cfg_t;

endpackage

// File: hw/rtl/idpr_if.sv
// item and configuration channel interfaces

interface idpr_in_if;
	logic               valid;
	logic               ready;
	logic signed [7:0]  lhs_byte;
	logic signed [7:0]  rhs_byte;
	logic               first;
	logic               last;
	logic signed [31:0] start_value;
	logic signed [31:0] multiplier;
	logic signed [5:0]  shift;

	modport source (output valid, lhs_byte, rhs_byte, first, last, start_value, multiplier,
		shift, input ready);
	modport sink (input valid, lhs_byte, rhs_byte, first, last, start_value, multiplier,
		shift, output ready);
endinterface

interface idpr_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] result;

	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

interface idpr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [idpr_pkg::CfgIndexWidth-1:0] index;
	logic [idpr_pkg::CfgDataWidth-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/idpr_cfg_regs.sv
// configuration registers of the block
module idpr_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	idpr_cfg_if.sink            cfg,
	output idpr_pkg::idpr_cfg_t regs
);

	idpr_pkg::idpr_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lhs_zp     <= idpr_pkg::LhsZpReset;
			regs_q.out_offset <= idpr_pkg::OutOffsetReset;
			regs_q.act_min    <= idpr_pkg::ActMinReset;
			regs_q.act_max    <= idpr_pkg::ActMaxReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				idpr_pkg::REG_LHS_ZP:     regs_q.lhs_zp     <= cfg.data;
				idpr_pkg::REG_OUT_OFFSET: regs_q.out_offset <= cfg.data[7:0];
				idpr_pkg::REG_ACT_MIN:    regs_q.act_min    <= cfg.data[7:0];
				idpr_pkg::REG_ACT_MAX:    regs_q.act_max    <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/idpr_ctrl.sv
// controller state machine: item acceptance and requantize sequencing
module idpr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output idpr_pkg::idpr_cmd_t cmd
);

	idpr_pkg::idpr_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idpr_pkg::ST_IDLE:   if (in_valid && in_last) state_d = idpr_pkg::ST_SHIFT;
			idpr_pkg::ST_SHIFT:  state_d = idpr_pkg::ST_MUL;
			idpr_pkg::ST_MUL:    state_d = idpr_pkg::ST_HIGH;
			idpr_pkg::ST_HIGH:   state_d = idpr_pkg::ST_ROUND;
			idpr_pkg::ST_ROUND:  state_d = idpr_pkg::ST_FINISH;
			idpr_pkg::ST_FINISH: if (out_free) state_d = idpr_pkg::ST_IDLE;
			default:             state_d = idpr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			idpr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.mac  = in_valid;
			end
			idpr_pkg::ST_SHIFT:  cmd.shift  = 1'b1;
			idpr_pkg::ST_MUL:    cmd.mul    = 1'b1;
			idpr_pkg::ST_HIGH:   cmd.high   = 1'b1;
			idpr_pkg::ST_ROUND:  cmd.rnd    = 1'b1;
			idpr_pkg::ST_FINISH: cmd.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idpr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/idpr_datapath.sv
// multiply-accumulate and requantize datapath
module idpr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  idpr_pkg::idpr_cmd_t cmd,
	input  idpr_pkg::idpr_cfg_t regs,
	input  logic signed [7:0]   lhs_byte,
	input  logic signed [7:0]   rhs_byte,
	input  logic                first,
	input  logic signed [31:0]  start_value,
	input  logic signed [31:0]  multiplier,
	input  logic signed [5:0]   shift,
	output logic signed [7:0]   result
);

	logic signed [31:0] acc_q;
	logic signed [31:0] mult_q;
	logic signed [5:0]  shift_q;

	logic signed [9:0]  lhs_adj;
	logic signed [17:0] prod;
	logic signed [31:0] acc_base;

	assign lhs_adj  = 10'(lhs_byte) + 10'(regs.lhs_zp);
	assign prod     = 18'(lhs_adj) * 18'(rhs_byte);
	assign acc_base = first ? start_value : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			mult_q  <= '0;
			shift_q <= '0;
		end else if (cmd.mac) begin
			acc_q <= acc_base + 32'(prod);
			if (first) begin
				mult_q  <= multiplier;
				shift_q <= shift;
			end
		end
	end

	// left shift before the multiply, or right shift amount after it
	logic signed [31:0] val_q;
	logic [4:0]         rs_q;
	logic signed [5:0]  neg_shift;

	assign neg_shift = -shift_q;

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			if (shift_q > 6'sd0) begin
				val_q <= acc_q << shift_q[4:0];
				rs_q  <= '0;
			end else begin
				val_q <= acc_q;
				rs_q  <= (shift_q[5] && shift_q[4:0] == 5'd0) ? 5'd31 : neg_shift[4:0];
			end
		end
	end

	logic signed [63:0] prod_q;
	logic               sat_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= 64'(val_q) * 64'(mult_q);
			sat_q  <= (val_q == 32'sh8000_0000) && (mult_q == 32'sh8000_0000);
		end
	end

	// rounding doubling high half: floor((p + 2^30) / 2^31) for either sign
	logic signed [63:0] prod_rnd;
	logic signed [31:0] high_q;

	assign prod_rnd = prod_q + 64'sd1073741824;

	always_ff @(posedge clk) begin
		if (cmd.high) begin
			high_q <= sat_q ? 32'sh7fff_ffff : prod_rnd[62:31];
		end
	end

	logic [31:0]        mask;
	logic [31:0]        rem;
	logic [31:0]        thr;
	logic signed [31:0] floor_val;
	logic signed [31:0] rnd_q;

	assign mask      = (32'd1 << rs_q) - 32'd1;
	assign rem       = high_q & mask;
	assign thr       = (mask >> 1) + 32'(high_q[31]);
	assign floor_val = high_q >>> rs_q;

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			rnd_q <= floor_val + 32'(rem > thr);
		end
	end

	logic signed [32:0] with_off;
	logic signed [32:0] lim_hi;
	logic signed [7:0]  result_q;

	assign with_off = 33'(rnd_q) + 33'(regs.out_offset);
	assign lim_hi   = (with_off > 33'(regs.act_max)) ? 33'(regs.act_max) : with_off;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= (lim_hi < 33'(regs.act_min)) ? regs.act_min : lim_hi[7:0];
		end
	end

	assign result = result_q;

endmodule

// File: hw/rtl/int8_dot_product_requantize_top.sv
// top level of the int8 dot product with per-channel requantization
// latency: a last item's result becomes valid when the finish state has registered it
// throughput: items without last go in one per cycle while idle (one 10x8 mac each)
// an item with last stalls the input for the shift, 32x32 multiply, rounding high half,
// rounding shift, offset and clamp, longer while the previous result is not taken
// reset (arst_n, async): accumulator, held multiplier and shift cleared, limits -128/127
module int8_dot_product_requantize_top (
	input  logic        clk,
	input  logic        arst_n,
	idpr_in_if.sink     req,
	idpr_out_if.source  rsp,
	idpr_cfg_if.sink    cfg
);

	// configuration block, always ready
	idpr_pkg::idpr_cfg_t regs;

	idpr_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// controller: takes items in idle, steps the requantize sequence after last
	idpr_pkg::idpr_cmd_t cmd;

	idpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_last   (req.last),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: accumulator, held channel data and the requantize stages
	idpr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.regs        (regs),
		.lhs_byte    (req.lhs_byte),
		.rhs_byte    (req.rhs_byte),
		.first       (req.first),
		.start_value (req.start_value),
		.multiplier  (req.multiplier),
		.shift       (req.shift),
		.result      (rsp.result)
	);

	// a last item starts the requantize sequence, so input stalls next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.last |=> !req.ready)
		else $error("input not stalled after last item");

	// an item without last never stalls the following one
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && !req.last |=> req.ready)
		else $error("input stalled after non-last item");

	// with ordered limits the result lies within them
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (regs.act_min <= regs.act_max) |->
		(rsp.result >= regs.act_min) && (rsp.result <= regs.act_max))
		else $error("result outside activation limits");

endmodule

// File: bench/testbench.sv
// self-checking testbench of the int8 dot product requantize block
`timescale 1ns / 1ps

module testbench;

	// run bounds: cycle limit and settle time in clock cycles, then phase and item counts
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned SettleCycles = 10;
	localparam int unsigned PhaseCount   = 8;
	localparam int unsigned PhaseItems   = 194;

	localparam longint MinQ31   = -64'sd2147483648;
	localparam longint MaxQ31   = 64'sd2147483647;
	localparam longint TwoPow31 = 64'sd2147483648;
	localparam longint Nudge    = 64'sd1073741824;

	// one multiply-accumulate item as the block sees it
	typedef struct {
		logic signed [7:0]  lhs;
		logic signed [7:0]  rhs;
		logic               first;
		logic               last;
		logic signed [31:0] start;
		logic signed [31:0] mult;
		logic signed [5:0]  shift;
	} mac_item_t;

	// mirrors the accumulator, the held channel parameters and the registers,
	// and keeps the int8 outputs still owed by the block
	class dot_product_tracker;
		logic signed [8:0] lhs_zp;
		logic signed [7:0] out_offset;
		logic signed [7:0] act_min;
		logic signed [7:0] act_max;
		logic [31:0]       acc;
		logic [31:0]       held_mult;
		logic [5:0]        held_shift;
		logic signed [7:0] owed_outputs[$];
		int unsigned       mismatches;
		int unsigned       outputs_checked;
		int unsigned       items_noted;

		function new();
			lhs_zp = idpr_pkg::LhsZpReset;
			out_offset = idpr_pkg::OutOffsetReset;
			act_min = idpr_pkg::ActMinReset;
			act_max = idpr_pkg::ActMaxReset;
			acc = '0;
			held_mult = '0;
			held_shift = '0;
			mismatches = 0;
			outputs_checked = 0;
			items_noted = 0;
		endfunction

		function void apply_config(logic [idpr_pkg::CfgIndexWidth-1:0] index, logic [8:0] data);
			case (index)
				idpr_pkg::REG_LHS_ZP: lhs_zp = data;
				idpr_pkg::REG_OUT_OFFSET: out_offset = data[7:0];
				idpr_pkg::REG_ACT_MIN: act_min = data[7:0];
				idpr_pkg::REG_ACT_MAX: act_max = data[7:0];
				default: ;
			endcase
		endfunction

		// saturating doubling high multiply, rounding shift, offset and clamp
		function logic signed [7:0] requantized();
			logic [31:0] shifted;
			longint      v;
			longint      p;
			longint      q;
			longint      r;
			longint      mask;
			longint      rem;
			longint      thr;
			int          sh;
			int unsigned rs;
			sh = $signed(held_shift);
			rs = 0;
			if (sh > 0) begin
				shifted = acc << sh;
				v = longint'($signed(shifted));
			end else begin
				v = longint'($signed(acc));
				rs = (sh < -31) ? 31 : -sh;
			end
			if (v == MinQ31 && longint'($signed(held_mult)) == MinQ31) begin
				q = MaxQ31;
			end else begin
				p = v * longint'($signed(held_mult));
				p = p + ((p >= 0) ? Nudge : 64'sd1 - Nudge);
				q = p / TwoPow31;
			end
			// round to nearest, ties away from zero
			mask = (64'sd1 << rs) - 64'sd1;
			rem = q & mask;
			thr = mask >>> 1;
			r = q >>> rs;
			if (r < 0)
				thr++;
			if (rem > thr)
				r++;
			v = r + longint'(out_offset);
			if (v > longint'(act_max))
				v = act_max;
			if (v < longint'(act_min))
				v = act_min;
			return v[7:0];
		endfunction

		function void note_item(mac_item_t it);
			int lhs_term;
			lhs_term = int'(it.lhs) + int'(lhs_zp);
			if (it.first) begin
				acc = it.start;
				held_mult = it.mult;
				held_shift = it.shift;
			end
			acc = acc + 32'(lhs_term * int'(it.rhs));
			items_noted++;
			if (it.last)
				owed_outputs.push_back(requantized());
		endfunction

		function void check_result(logic signed [7:0] actual);
			logic signed [7:0] owed;
			outputs_checked++;
			if (owed_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: result %0d with no output owed", $time, actual);
			end else begin
				owed = owed_outputs.pop_front();
				if (actual !== owed) begin
					mismatches++;
					$display("%0t: result mismatch, expected %0d, got %0d", $time, owed, actual);
				end
			end
		endfunction

		function int unsigned owed_count();
			return owed_outputs.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned cycle_count = 0;

	idpr_in_if  req_ch();
	idpr_out_if rsp_ch();
	idpr_cfg_if cfg_ch();

	dot_product_tracker tracker = new();

	int8_dot_product_requantize_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("[int8_dot_product_requantize_top] ERROR");
			$finish;
		end
	end

	// present one item, hold it until the block takes it, then predict
	task automatic send_item(mac_item_t it);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.lhs_byte <= it.lhs;
		req_ch.rhs_byte <= it.rhs;
		req_ch.first <= it.first;
		req_ch.last <= it.last;
		req_ch.start_value <= it.start;
		req_ch.multiplier <= it.mult;
		req_ch.shift <= it.shift;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_item(it);
	endtask

	task automatic send_fields(logic signed [7:0] lhs, logic signed [7:0] rhs, logic first,
		logic last, logic signed [31:0] start, logic signed [31:0] mult, logic signed [5:0] shift);
		mac_item_t it;
		it.lhs = lhs;
		it.rhs = rhs;
		it.first = first;
		it.last = last;
		it.start = start;
		it.mult = mult;
		it.shift = shift;
		send_item(it);
	endtask

	// item with every field random; first and last as given
	function automatic mac_item_t random_item(logic first, logic last);
		mac_item_t it;
		it.lhs = 8'($urandom);
		it.rhs = 8'($urandom);
		it.first = first;
		it.last = last;
		it.start = $urandom;
		it.mult = $urandom;
		it.shift = 6'($urandom);
		return it;
	endfunction

	// one well-formed dot product: first item loads the channel, last one emits
	task automatic send_dot_product();
		mac_item_t   head;
		mac_item_t   it;
		int unsigned len;
		head = random_item(1'b1, 1'b0);
		len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 48);
		// mostly channel parameters of a real layer, so outputs land inside the limits
		if ($urandom_range(0, 9) < 7) begin
			head.start = $urandom_range(0, 20000) - 10000;
			head.mult = $urandom_range(32'h7fffffff, 32'h40000000);
			if ($urandom_range(0, 9) == 0)
				head.mult = -head.mult;
			head.shift = 6'(-int'($urandom_range(3, 11)));
			if ($urandom_range(0, 9) == 0)
				head.shift = 6'($urandom_range(1, 2));
		end
		for (int unsigned k = 0; k < len; k++) begin
			it = (k == 0) ? head : random_item(1'b0, 1'b0);
			it.last = (k == len - 1);
			send_item(it);
		end
	endtask

	// broken sequences: first and last at random
	task automatic send_noise();
		int unsigned len;
		len = $urandom_range(1, 4);
		repeat (len) send_item(random_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
	endtask

	// hold the sender until every owed output is in, then let the pipeline settle
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (tracker.owed_count() > 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// back-to-back register writes; valid stays high across them
	task automatic write_reg(logic [idpr_pkg::CfgIndexWidth-1:0] index, int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= value[8:0];
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_config(index, value[8:0]);
	endtask

	task automatic configure(int lhs_off, int out_off, int lo, int hi);
		write_reg(idpr_pkg::REG_LHS_ZP, lhs_off);
		write_reg(idpr_pkg::REG_OUT_OFFSET, out_off);
		write_reg(idpr_pkg::REG_ACT_MIN, lo);
		write_reg(idpr_pkg::REG_ACT_MAX, hi);
		cfg_ch.valid <= 1'b0;
	endtask

	// per-phase register settings: extremes first, then narrow, inverted, pinned and ordered
	// random limits, pinned again, and fully random settings last
	task automatic configure_phase(int unsigned phase);
		int a;
		int b;
		a = $urandom_range(0, 255) - 128;
		b = $urandom_range(0, 255) - 128;
		case (phase)
			1: configure(128, 127, -128, 127);
			2: configure(-127, -128, -128, 127);
			3: configure(0, 0, -20, 20);
			4: configure($urandom_range(0, 255) - 127, a, 60, -60);
			5: configure(-1, 127, -128, -128);
			6: configure($urandom_range(0, 255) - 127, a, (a < b) ? a : b, (a < b) ? b : a);
			7: configure(5, -3, 127, 127);
			default: configure($urandom_range(0, 255) - 127, $urandom_range(0, 255) - 128, a, b);
		endcase
	endtask

	// result side: random stall before each result, none during steady phases
	initial begin : result_sink
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			tracker.check_result(rsp_ch.result);
		end
	end

	initial begin : stimulus
		int unsigned phase_start;
		steady = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.lhs_byte <= '0;
		req_ch.rhs_byte <= '0;
		req_ch.first <= 1'b0;
		req_ch.last <= 1'b0;
		req_ch.start_value <= '0;
		req_ch.multiplier <= '0;
		req_ch.shift <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		// no first since reset: held multiplier and shift are still zero
		send_fields(8'sd5, 8'sd7, 1'b0, 1'b1, 32'sd0, 32'sd0, 6'sd0);
		// after last the sum is kept and keeps growing
		send_fields(-8'sd128, -8'sd128, 1'b0, 1'b0, 32'sd0, 32'sd0, 6'sd0);
		send_fields(8'sd127, 8'sd127, 1'b0, 1'b1, 32'sd0, 32'sd0, 6'sd0);
		// first and last together, field extremes
		send_fields(8'sd127, -8'sd128, 1'b1, 1'b1, 32'sd1000, 32'h7fffffff, 6'sd0);
		send_fields(-8'sd128, 8'sd127, 1'b1, 1'b1, -32'sd900, 32'h7fffffff, -6'sd4);
		// both multiply operands at -2^31: high multiply saturates
		send_fields(8'sd0, 8'sd99, 1'b1, 1'b1, 32'h80000000, 32'h80000000, 6'sd0);
		// accumulator wraps, and a shift of -32 is taken as 31
		send_fields(-8'sd128, -8'sd128, 1'b1, 1'b1, 32'h7fffffff, 32'h40000000, -6'sd32);
		// left shift wraps before the multiply
		send_fields(8'sd1, 8'sd1, 1'b1, 1'b1, 32'sd12345, 32'h7fffffff, 6'sd31);
		send_fields(8'sd3, -8'sd1, 1'b1, 1'b1, 32'h01234567, 32'h5a5a5a5a, 6'sd7);
		// short dot product
		send_fields(-8'sd128, 8'sd127, 1'b1, 1'b0, 32'sd0, 32'h55555555, -6'sd3);
		send_fields(8'sd127, -8'sd128, 1'b0, 1'b0, 32'sd0, 32'sd0, 6'sd0);
		send_fields(8'sd50, 8'sd60, 1'b0, 1'b1, 32'sd0, 32'sd0, 6'sd0);
		send_fields(8'sd0, 8'sd0, 1'b1, 1'b1, 32'h80000000, 32'h7fffffff, -6'sd31);
		send_fields(-8'sd1, -8'sd1, 1'b1, 1'b1, -32'sd1000, 32'h60000000, 6'sd5);
		// rounding ties on both signs
		send_fields(8'sd1, 8'sd0, 1'b1, 1'b1, 32'sd6, 32'h7fffffff, -6'sd2);
		send_fields(8'sd1, 8'sd0, 1'b1, 1'b1, -32'sd6, 32'h7fffffff, -6'sd2);
		// a second first cuts the open dot product short
		send_fields(8'sd9, 8'sd9, 1'b1, 1'b0, 32'sd77, 32'h40000000, -6'sd1);
		send_fields(8'sd4, -8'sd4, 1'b1, 1'b1, 32'sd100, 32'h40000000, -6'sd1);

		// random phases, each under its own register settings; every phase
		// starts with the sender held until the block has drained
		for (int unsigned phase = 1; phase <= PhaseCount; phase++) begin
			wait_idle();
			configure_phase(phase);
			steady = (phase == 3 || phase == 6);
			phase_start = tracker.items_noted;
			while (tracker.items_noted - phase_start < PhaseItems) begin
				if ($urandom_range(0, 9) < 8)
					send_dot_product();
				else
					send_noise();
			end
		end
		steady = 1'b0;

		wait_idle();
		$display("covered %0d items and %0d outputs over %0d register settings in %0d cycles",
			tracker.items_noted, tracker.outputs_checked, PhaseCount + 1, cycle_count);
		$display("mismatches: %0d, outputs still owed: %0d", tracker.mismatches,
			tracker.owed_count());
		if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
			$display("[int8_dot_product_requantize_top] OK");
		end else begin
			$display("[int8_dot_product_requantize_top] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/idpr_pkg.sv
hw/rtl/idpr_if.sv
hw/rtl/idpr_cfg_regs.sv
hw/rtl/idpr_ctrl.sv
hw/rtl/idpr_datapath.sv
hw/rtl/int8_dot_product_requantize_top.sv
bench/testbench.sv
